### design/fcwe_pkg.sv
// Package for the front coding word encoder: constants, state and command types.
// Used by fcwe_ctrl, fcwe_datapath and front_coding_word_encoder_top.
`default_nettype none

package fcwe_pkg;

  localparam int unsigned MAX_WORD_DEF = 32;    // default stored word length
  localparam int unsigned POS_W        = 7;     // position and length width
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned AFFIX_W      = 11;
  localparam int unsigned CNT_W        = 4;
  localparam logic [POS_W-1:0] CNT_CAP  = 7'd15;  // header count cap, first replayed position
  localparam logic [POS_W-1:0] POS_MAX  = 7'd127; // position counter saturation

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_HI,
    ST_HDR_LO,
    ST_REPLAY,
    ST_CHAR
  } state_e;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_DIRECT,
    LD_HDR_HI,
    LD_HDR_LO,
    LD_REPLAY,
    LD_CHAR
  } load_e;

  typedef struct packed {
    logic  fire;         // input transfer this cycle
    load_e load;         // what goes into the output register
    logic  rep_start;    // restart replay counter at the first replayed position
    logic  rep_step;     // advance replay counter
    logic  next_replay;  // next cycle is a replay cycle: point the store read there
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_load;   // output register free or draining
    logic need_hdr;   // present input item opens a header
    logic pass_char;  // present input item passes straight through
    logic has_replay; // latched shared count reaches past the header cap
    logic rep_last;   // replay counter at last shared position
    logic emit_char;  // the item's character follows the header
  } dp_stat_t;

endpackage

`default_nettype wire

### design/fcwe_ctrl.sv
// Controller state machine of the front coding word encoder.
// Depends on fcwe_pkg; drives fcwe_datapath through ctrl_cmd_t.
`default_nettype none

module fcwe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire fcwe_pkg::dp_stat_t stat_i,
  output fcwe_pkg::ctrl_cmd_t    cmd_o
);

  fcwe_pkg::state_e state_q, state_d;
  logic             fire;

  assign s_tready_o = (state_q == fcwe_pkg::ST_IDLE) && stat_i.can_load;
  assign fire       = s_tready_o && s_tvalid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcwe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fcwe_pkg::ST_IDLE: begin
        if (fire && stat_i.need_hdr) state_d = fcwe_pkg::ST_HDR_HI;
      end
      fcwe_pkg::ST_HDR_HI: begin
        if (stat_i.can_load) state_d = fcwe_pkg::ST_HDR_LO;
      end
      fcwe_pkg::ST_HDR_LO: begin
        if (stat_i.can_load) begin
          if (stat_i.has_replay)     state_d = fcwe_pkg::ST_REPLAY;
          else if (stat_i.emit_char) state_d = fcwe_pkg::ST_CHAR;
          else                       state_d = fcwe_pkg::ST_IDLE;
        end
      end
      fcwe_pkg::ST_REPLAY: begin
        if (stat_i.can_load && stat_i.rep_last) begin
          state_d = stat_i.emit_char ? fcwe_pkg::ST_CHAR : fcwe_pkg::ST_IDLE;
        end
      end
      fcwe_pkg::ST_CHAR: begin
        if (stat_i.can_load) state_d = fcwe_pkg::ST_IDLE;
      end
      default: state_d = fcwe_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = fcwe_pkg::LD_NONE;
    cmd_o.fire        = fire;
    cmd_o.next_replay = (state_d == fcwe_pkg::ST_REPLAY);
    case (state_q)
      fcwe_pkg::ST_IDLE: begin
        if (fire && stat_i.pass_char) cmd_o.load = fcwe_pkg::LD_DIRECT;
      end
      fcwe_pkg::ST_HDR_HI: begin
        if (stat_i.can_load) cmd_o.load = fcwe_pkg::LD_HDR_HI;
      end
      fcwe_pkg::ST_HDR_LO: begin
        if (stat_i.can_load) begin
          cmd_o.load      = fcwe_pkg::LD_HDR_LO;
          cmd_o.rep_start = 1'b1;
        end
      end
      fcwe_pkg::ST_REPLAY: begin
        if (stat_i.can_load) begin
          cmd_o.load     = fcwe_pkg::LD_REPLAY;
          cmd_o.rep_step = 1'b1;
        end
      end
      fcwe_pkg::ST_CHAR: begin
        if (stat_i.can_load) cmd_o.load = fcwe_pkg::LD_CHAR;
      end
      default: cmd_o.load = fcwe_pkg::LD_NONE;
    endcase
  end

endmodule

`default_nettype wire

### design/fcwe_datapath.sv
// Datapath of the front coding word encoder: previous-word store, match logic,
// header build, replay counter and output register. Depends on fcwe_pkg.
`default_nettype none

module fcwe_datapath #(
  parameter int unsigned MAX_WORD = fcwe_pkg::MAX_WORD_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [fcwe_pkg::CHAR_W-1:0]   in_char_i,
  input  wire logic                          word_end_i,
  input  wire logic [fcwe_pkg::AFFIX_W-1:0]  affix_index_i,
  input  wire fcwe_pkg::ctrl_cmd_t           cmd_i,
  output fcwe_pkg::dp_stat_t                 stat_o,
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  output logic [fcwe_pkg::CHAR_W-1:0]        out_byte_o,
  output logic                               run_end_o,
  output logic                               record_end_o,
  output logic                               overflow_o
);

  localparam int unsigned PW = fcwe_pkg::POS_W;
  localparam int unsigned CW = fcwe_pkg::CHAR_W;
  localparam int unsigned AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam logic [PW-1:0] MAXW = PW'(MAX_WORD);

  // previous word store
  logic [CW-1:0] mem [MAX_WORD];
  logic [CW-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we;

  // word tracking
  logic [PW-1:0] pos_q, pos_d, len_q, len_d;
  logic          still_q, still_d;

  // latched header job
  logic [15:0]   hdr_q;
  logic [PW-1:0] j_q, rep_q, rep_d;
  logic          emit_char_q, last_q, ovf_q;
  logic [CW-1:0] ch_q;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] out_byte_q, out_byte_d;
  logic          out_run_q, out_run_d, out_rec_q, out_rec_d, out_ovf_q, out_ovf_d;

  logic                         ovf_in, match, hold_match, need_hdr;
  logic [PW-1:0]                pos_inc, j_new, rd_sel;
  logic [fcwe_pkg::CNT_W-1:0]   cnt;
  logic [15:0]                  hdr_new;
  logic                         can_load, has_replay, rep_last;

  assign ovf_in     = (pos_q >= MAXW);
  assign pos_inc    = pos_q + PW'(1);
  assign match      = still_q && !ovf_in && (pos_q < len_q) && (rd_q == in_char_i);
  assign hold_match = match && !word_end_i && (pos_inc < MAXW);
  assign need_hdr   = still_q && !hold_match;
  assign j_new      = (match && word_end_i) ? pos_inc : pos_q;
  assign cnt        = (j_new > fcwe_pkg::CNT_CAP) ? fcwe_pkg::CNT_W'(fcwe_pkg::CNT_CAP)
                                                  : j_new[fcwe_pkg::CNT_W-1:0];
  assign hdr_new    = {1'b1, cnt, affix_index_i};

  assign can_load   = !out_valid_q || m_tready_i;
  assign has_replay = (j_q > fcwe_pkg::CNT_CAP);
  assign rep_last   = ((rep_q + PW'(1)) >= j_q);

  assign stat_o.can_load   = can_load;
  assign stat_o.need_hdr   = need_hdr;
  assign stat_o.pass_char  = !still_q;
  assign stat_o.has_replay = has_replay;
  assign stat_o.rep_last   = rep_last;
  assign stat_o.emit_char  = emit_char_q;

  // next word tracking state
  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    still_d = still_q;
    if (cmd_i.fire) begin
      if (word_end_i) begin
        pos_d   = '0;
        len_d   = ovf_in ? MAXW : pos_inc;
        still_d = 1'b1;
      end else begin
        if (pos_q < fcwe_pkg::POS_MAX) pos_d = pos_inc;
        if (need_hdr) still_d = 1'b0;
      end
    end
  end

  always_comb begin
    rep_d = rep_q;
    if (cmd_i.rep_start)     rep_d = fcwe_pkg::CNT_CAP;
    else if (cmd_i.rep_step) rep_d = rep_q + PW'(1);
  end

  // point the read at the next replay position or the next item's position
  assign rd_sel  = cmd_i.next_replay ? rep_d : pos_d;
  assign rd_addr = (rd_sel < MAXW) ? rd_sel[AW-1:0] : '0;
  assign wr_addr = pos_q[AW-1:0];
  assign we      = cmd_i.fire && !ovf_in;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= in_char_i;
    // forward a same-cycle write (one-character word followed by its successor)
    if (we && (wr_addr == rd_addr)) rd_q <= in_char_i;
    else                            rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire && need_hdr) begin
      hdr_q       <= hdr_new;
      j_q         <= j_new;
      emit_char_q <= !(match && word_end_i);
      ch_q        <= in_char_i;
      last_q      <= word_end_i;
      ovf_q       <= ovf_in;
    end
    rep_q <= rep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      still_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      still_q <= still_d;
    end
  end

  // output register load
  always_comb begin
    out_valid_d = out_valid_q && !m_tready_i;
    out_byte_d  = out_byte_q;
    out_run_d   = out_run_q;
    out_rec_d   = out_rec_q;
    out_ovf_d   = out_ovf_q;
    case (cmd_i.load)
      fcwe_pkg::LD_NONE: begin
        out_valid_d = out_valid_q && !m_tready_i;
      end
      fcwe_pkg::LD_DIRECT: begin
        out_valid_d = 1'b1;
        out_byte_d  = in_char_i;
        out_run_d   = 1'b1;
        out_rec_d   = word_end_i;
        out_ovf_d   = ovf_in;
      end
      fcwe_pkg::LD_HDR_HI: begin
        out_valid_d = 1'b1;
        out_byte_d  = hdr_q[15:8];
        out_run_d   = 1'b0;
        out_rec_d   = 1'b0;
        out_ovf_d   = ovf_q;
      end
      fcwe_pkg::LD_HDR_LO: begin
        out_valid_d = 1'b1;
        out_byte_d  = hdr_q[7:0];
        out_run_d   = !has_replay && !emit_char_q;
        out_rec_d   = !has_replay && !emit_char_q && last_q;
        out_ovf_d   = ovf_q;
      end
      fcwe_pkg::LD_REPLAY: begin
        out_valid_d = 1'b1;
        out_byte_d  = rd_q;
        out_run_d   = rep_last && !emit_char_q;
        out_rec_d   = rep_last && !emit_char_q && last_q;
        out_ovf_d   = ovf_q;
      end
      fcwe_pkg::LD_CHAR: begin
        out_valid_d = 1'b1;
        out_byte_d  = ch_q;
        out_run_d   = 1'b1;
        out_rec_d   = last_q;
        out_ovf_d   = ovf_q;
      end
      default: begin
        out_valid_d = out_valid_q && !m_tready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_run_q  <= out_run_d;
    out_rec_q  <= out_rec_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_tvalid_o   = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = out_run_q;
  assign record_end_o = out_rec_q;
  assign overflow_o   = out_ovf_q;

endmodule

`default_nettype wire

### design/front_coding_word_encoder_top.sv
// Front coding word encoder, top level. Depends on fcwe_pkg, fcwe_ctrl, fcwe_datapath.
// One character per cycle while it matches or passes straight through, unless the output
// stalls; a header item emits two header bytes, a replayed byte per shared character past
// the 15th and its character if it follows. A passed character shows in the cycle after its
// transfer; a header is latched, then its high byte loaded. Reset (rst_ni low, async) clears
// position, length, match flag, state and output valid; the word store needs no clearing.
`default_nettype none

module front_coding_word_encoder_top #(
  parameter int unsigned MAX_WORD = fcwe_pkg::MAX_WORD_DEF  // stored word length, 16..64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream: one character of a sorted word per transfer
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [7:0] in_char, [18:8] affix_index, rest zero
  input  wire logic        s_axis_tlast_i,   // word_end
  // output stream: encoded dictionary bytes
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  output logic             m_axis_tlast_o,   // run_end: last byte caused by an input transfer
  output logic [1:0]       m_axis_tuser_o    // [0] record_end, [1] overflow
);

  fcwe_pkg::ctrl_cmd_t cmd;
  fcwe_pkg::dp_stat_t  stat;
  logic                record_end, overflow;

  // The controller sequences header, replay and trailing-character bytes;
  // everything it decides on comes from the datapath status and the input valid.
  fcwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the previous word in a small RAM, prefetching the entry
  // for the next character position so each compare sees registered data.
  fcwe_datapath #(
    .MAX_WORD (MAX_WORD)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_char_i     (s_axis_tdata_i[7:0]),
    .word_end_i    (s_axis_tlast_i),
    .affix_index_i (s_axis_tdata_i[18:8]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .run_end_o     (m_axis_tlast_o),
    .record_end_o  (record_end),
    .overflow_o    (overflow)
  );

  assign m_axis_tuser_o = {overflow, record_end};

endmodule

`default_nettype wire
